@@ src/ibc_pkg.sv @@
// ============================================================================
// ibc_pkg : shared definitions for the interval bin classifier
// Sizes, codes, the pipeline item record and small helper functions.
// ============================================================================
`default_nettype none

package ibc_pkg;

   // Table depth and value width
   localparam int MAX_BREAKS  = 64;
   localparam int VALUE_WIDTH = 32;

   // Derived sizes
   localparam int ADDR_W       = (MAX_BREAKS > 2) ? $clog2(MAX_BREAKS) : 1;
   localparam int CNT_W        = $clog2(MAX_BREAKS + 1);
   localparam int CODE_W       = CNT_W;
   localparam int SEARCH_STEPS = ADDR_W;
   localparam int NUM_STAGES   = SEARCH_STEPS + 3;
   localparam int LATENCY      = NUM_STAGES + 1;

   // Fixed field widths
   localparam int INDEX_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAK_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_CLOSED   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCLUDE_BORDER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_RANGE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETURN_CODES   = 3'd4;

   // Item kinds
   localparam logic KIND_LOAD     = 1'b0;
   localparam logic KIND_CLASSIFY = 1'b1;

   // Classification outcome carried down the pipe
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_NOBIN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CAPTURE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd2;

   // One pipeline slot
   typedef struct packed {
      logic                          valid;
      logic                          kind;
      logic [INDEX_W-1:0]            load_idx;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          missing;
      logic [MODE_W-1:0]             mode;
      logic signed [VALUE_WIDTH-1:0] b_first;
      logic [ADDR_W-1:0]             lo;
      logic [ADDR_W-1:0]             hi;
      logic [ADDR_W-1:0]             addr;
      logic [CODE_W-1:0]             code;
   } ibc_item_type;

   // Midpoint of a search window, rounded down
   function automatic logic [ADDR_W-1:0] mid_point(input logic [ADDR_W-1:0] lo,
                                                  input logic [ADDR_W-1:0] hi);
      logic [ADDR_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi};
      return sum[ADDR_W:1];
   endfunction

   // Saturate the break count to the table depth
   function automatic logic [CNT_W-1:0] limit_count(input logic [COUNT_W-1:0] count);
      if (int'(count) > MAX_BREAKS) begin
         return CNT_W'(MAX_BREAKS);
      end
      return CNT_W'(count);
   endfunction

   // One binary search step; item.addr holds the probed midpoint
   function automatic ibc_item_type search_step(input ibc_item_type item,
                                                input logic signed [VALUE_WIDTH-1:0] probe,
                                                input logic left_closed);
      ibc_item_type nxt;
      nxt = item;
      if (item.mode == MODE_SEARCH && (item.hi - item.lo) > ADDR_W'(1)) begin
         if (item.value > probe || (left_closed && item.value == probe)) begin
            nxt.lo = item.addr;
         end else begin
            nxt.hi = item.addr;
         end
      end
      nxt.addr = mid_point(nxt.lo, nxt.hi);
      return nxt;
   endfunction

endpackage

`default_nettype wire

@@ src/ibc_table_stage.sv @@
// ============================================================================
// ibc_table_stage : one pipeline stage with its own copy of the break table
// Registers the incoming slot and reads the table at the slot's address.
// Load beats write this copy as they pass, so each copy sees writes and
// reads in beat order.
// ============================================================================
`default_nettype none

module ibc_table_stage (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ibc_pkg::ibc_item_type                  stage_in,
   output      ibc_pkg::ibc_item_type                  stage_out,
   output      logic signed [ibc_pkg::VALUE_WIDTH-1:0] rdata
);
   import ibc_pkg::*;

   logic signed [VALUE_WIDTH-1:0] break_mem [MAX_BREAKS];
   logic signed [VALUE_WIDTH-1:0] rdata_ff;
   ibc_item_type                  item_ff;
   logic                          write_en;

   // Load beat with an index inside the table
   assign write_en = stage_in.valid && stage_in.kind == KIND_LOAD &&
                     (int'(stage_in.load_idx) < MAX_BREAKS);

   // Table copy: one write, one registered read
   always_ff @(posedge clock) begin
      if (write_en) begin
         break_mem[ADDR_W'(stage_in.load_idx)] <= stage_in.value;
      end
      rdata_ff <= break_mem[stage_in.addr];
   end

   // Slot register; only valid is reset
   always_ff @(posedge clock) begin
      item_ff <= stage_in;
      if (reset) begin
         item_ff.valid <= 1'b0;
      end
   end

   assign stage_out = item_ff;
   assign rdata     = rdata_ff;

endmodule

`default_nettype wire

@@ src/interval_bin_classifier_top.sv @@
// ============================================================================
// interval_bin_classifier_top : pipelined binary-search interval classifier
// A new beat is taken on every clock (busy is high only while reset is held)
// and each classify beat answers with a one-cycle rsp_valid strobe; load
// beats give no answer. The answer passes through one pipeline stage per
// table read, two for the outer breaks, one per halving of the window and
// one for the selected break, each stage with a table copy of its own,
// then the output register. Results cannot be held off.
// Registers are to be written through the csr_ port while no beat is in
// flight; the user is bound by this, the block itself does not enforce it.
// ============================================================================
`default_nettype none

module interval_bin_classifier_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request beat
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic                                   req_kind,
   input  wire logic [ibc_pkg::INDEX_W-1:0]            req_entry_index,
   input  wire logic signed [ibc_pkg::VALUE_WIDTH-1:0] req_sample,
   input  wire logic                                   req_is_missing,
   // response beat
   output      logic                                   rsp_valid,
   output      logic signed [ibc_pkg::VALUE_WIDTH-1:0] rsp_result,
   output      logic                                   rsp_no_bin,
   // register writes
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [ibc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [ibc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import ibc_pkg::*;

   // Configuration registers
   logic [COUNT_W-1:0] break_count_ff;
   logic               right_closed_ff;
   logic               include_border_ff;
   logic               capture_ff;
   logic               return_codes_ff;

   // Derived configuration
   logic [CNT_W-1:0]   count_used;
   logic [ADDR_W-1:0]  hi_cfg;
   logic               count_zero;
   logic               left_closed;
   logic               shift_code;

   // Pipeline slots
   ibc_item_type                  stage_in    [NUM_STAGES];
   ibc_item_type                  stage_out   [NUM_STAGES];
   logic signed [VALUE_WIDTH-1:0] stage_rdata [NUM_STAGES];

   // Decision stage
   ibc_item_type                  decide_item;
   logic signed [VALUE_WIDTH-1:0] edge_val;
   logic                          above_hi;
   logic                          below_lo;
   logic                          on_edge;
   logic                          captured;
   logic                          in_range;

   // Final index selection
   ibc_item_type                  last_item;
   logic [ADDR_W:0]               shift_idx;

   // Output register
   ibc_item_type                  fin;
   logic                          rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_result_ff;
   logic                          rsp_no_bin_ff;

   logic                          req_accept;

   assign busy       = reset;
   assign csr_ready  = !reset;
   assign req_accept = start && !busy;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         break_count_ff    <= COUNT_W'(2);
         right_closed_ff   <= 1'b1;
         include_border_ff <= 1'b0;
         capture_ff        <= 1'b0;
         return_codes_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BREAK_COUNT:    break_count_ff    <= csr_wdata;
            CSR_RIGHT_CLOSED:   right_closed_ff   <= csr_wdata[0];
            CSR_INCLUDE_BORDER: include_border_ff <= csr_wdata[0];
            CSR_CAPTURE_RANGE:  capture_ff        <= csr_wdata[0];
            CSR_RETURN_CODES:   return_codes_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign count_used  = limit_count(break_count_ff);
   assign hi_cfg      = ADDR_W'(count_used - CNT_W'(1));
   assign count_zero  = (break_count_ff == '0);
   assign left_closed = !right_closed_ff;
   assign shift_code  = right_closed_ff && capture_ff;

   // Stage 0 input: the accepted beat, probing the first break
   always_comb begin
      stage_in[0]          = '0;
      stage_in[0].valid    = req_accept;
      stage_in[0].kind     = req_kind;
      stage_in[0].load_idx = req_entry_index;
      stage_in[0].value    = req_sample;
      stage_in[0].missing  = req_is_missing;
      stage_in[0].mode     = MODE_NOBIN;
      stage_in[0].addr     = '0;
   end

   genvar k;
   for (k = 0; k < NUM_STAGES; k++) begin : g_stage
      ibc_table_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage_in[k]),
         .stage_out (stage_out[k]),
         .rdata     (stage_rdata[k])
      );
   end

   // Stage 1 input: keep the first break, probe the last one in use
   always_comb begin
      stage_in[1]         = stage_out[0];
      stage_in[1].b_first = stage_rdata[0];
      stage_in[1].addr    = hi_cfg;
   end

   // Outer border checks pick capture, search or no bin
   always_comb begin
      decide_item = stage_out[1];
      edge_val    = left_closed ? stage_rdata[1] : stage_out[1].b_first;
      above_hi    = stage_out[1].value > stage_rdata[1];
      below_lo    = stage_out[1].value < stage_out[1].b_first;
      on_edge     = stage_out[1].value == edge_val;
      captured    = capture_ff &&
                    ((!include_border_ff && on_edge) || (left_closed ? above_hi : below_lo));
      in_range    = !(below_lo || above_hi || (on_edge && !include_border_ff));
      if (stage_out[1].missing || count_zero) begin
         decide_item.mode = MODE_NOBIN;
      end else if (captured) begin
         decide_item.mode = MODE_CAPTURE;
      end else if (in_range) begin
         decide_item.mode = MODE_SEARCH;
      end else begin
         decide_item.mode = MODE_NOBIN;
      end
      decide_item.lo   = '0;
      decide_item.hi   = hi_cfg;
      decide_item.addr = mid_point('0, hi_cfg);
   end

   assign stage_in[2] = decide_item;

   // Search stages, one halving each
   for (k = 2; k < NUM_STAGES - 2; k++) begin : g_search
      assign stage_in[k+1] = search_step(stage_out[k], stage_rdata[k], left_closed);
   end

   // Last halving, then the bin code and the break to read
   always_comb begin
      last_item = search_step(stage_out[NUM_STAGES-2], stage_rdata[NUM_STAGES-2],
                              left_closed);
      shift_idx = {1'b0, last_item.lo} + (ADDR_W+1)'(shift_code);
      if (last_item.mode == MODE_CAPTURE) begin
         last_item.addr = left_closed ? hi_cfg : '0;
         last_item.code = CODE_W'(last_item.addr) + CODE_W'(1);
      end else begin
         last_item.code = CODE_W'(last_item.lo) + CODE_W'(1) + CODE_W'(shift_code);
         // single break with shifted code: clamp to the last break in use
         if (shift_idx > {1'b0, hi_cfg}) begin
            last_item.addr = hi_cfg;
         end else begin
            last_item.addr = shift_idx[ADDR_W-1:0];
         end
      end
   end

   assign stage_in[NUM_STAGES-1] = last_item;

   // Output register
   assign fin = stage_out[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid && fin.kind == KIND_CLASSIFY;
      end
   end

   always_ff @(posedge clock) begin
      rsp_no_bin_ff <= (fin.mode == MODE_NOBIN);
      if (fin.mode == MODE_NOBIN) begin
         rsp_result_ff <= '0;
      end else if (return_codes_ff) begin
         rsp_result_ff <= VALUE_WIDTH'(fin.code);
      end else begin
         rsp_result_ff <= stage_rdata[NUM_STAGES-1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_no_bin = rsp_no_bin_ff;

   // Every response beat comes from an accepted classify beat
   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept && req_kind == KIND_CLASSIFY, LATENCY))
      else $error("response without a matching classify beat");

   // A load beat never answers
   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_LOAD) |-> ##LATENCY !rsp_valid)
      else $error("load beat produced a response");

   // The search window has closed down by the final stage
   a_search_done : assert property (@(posedge clock) disable iff (reset)
      (fin.valid && fin.kind == KIND_CLASSIFY && fin.mode == MODE_SEARCH)
         |-> (fin.hi - fin.lo) <= ADDR_W'(1))
      else $error("binary search did not converge");

   // Bin codes stay within 1 and the table depth
   a_code_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_no_bin && $past(return_codes_ff))
         |-> (rsp_result >= 1 && rsp_result <= MAX_BREAKS))
      else $error("bin code out of range");

endmodule

`default_nettype wire

@@ tb/sv/tb_interval_bin_classifier_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_interval_bin_classifier_top : testbench for the interval bin classifier
// Loads break tables, writes the bin settings between phases and streams
// load and classify beats. A predictor tracks the table and the settings,
// works out the bin answer of every accepted classify beat, and a checker
// compares each response strobe with the oldest answer still pending.
// ============================================================================

module tb_interval_bin_classifier_top;
   import ibc_pkg::*;

   localparam int VW          = VALUE_WIDTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int RANDOM_BEATS  = 140;

   localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] ONE_Q16   = 32'sh0001_0000;

   // Indexes past the last defined register; writes there are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_RETURN_CODES + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = {CSR_INDEX_W{1'b1}};

   typedef struct {
      logic signed [VW-1:0] result;
      logic                 no_bin;
   } bin_answer_type;

   // DUT connections
   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_kind = KIND_LOAD;
   logic [INDEX_W-1:0]         req_entry_index = '0;
   logic signed [VW-1:0]       req_sample = '0;
   logic                       req_is_missing = 1'b0;
   logic                       rsp_valid;
   logic signed [VW-1:0]       rsp_result;
   logic                       rsp_no_bin;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Predictor state: break table and settings as the block should hold them
   logic signed [VW-1:0]       brk_tbl [MAX_BREAKS];
   logic [COUNT_W-1:0]         cfg_count   = 7'd2;
   bit                         cfg_right   = 1'b1;
   bit                         cfg_border  = 1'b0;
   bit                         cfg_capture = 1'b0;
   bit                         cfg_codes   = 1'b1;

   bin_answer_type             pending_bins [$];
   int                         fail_count = 0;
   int                         cycle_count = 0;
   int                         sender_idle_pct = 0;

   interval_bin_classifier_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_sample      (req_sample),
      .req_is_missing  (req_is_missing),
      .rsp_valid       (rsp_valid),
      .rsp_result      (rsp_result),
      .rsp_no_bin      (rsp_no_bin),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bin answer for one classify beat against the current table and settings
   function automatic bin_answer_type predict_bin(input logic signed [VW-1:0] v,
                                                  input bit missing);
      bin_answer_type       ans;
      int                   n, lo, hi, mid, idx, code;
      bit                   left, shift, hit;
      logic signed [VW-1:0] open_end;
      ans.result = '0;
      ans.no_bin = 1'b1;
      hit  = 1'b0;
      idx  = 0;
      code = 0;
      n = (int'(cfg_count) > MAX_BREAKS) ? MAX_BREAKS : int'(cfg_count);
      if (missing || n == 0) begin
         return ans;
      end
      left  = !cfg_right;
      shift = cfg_right && cfg_capture;
      lo = 0;
      hi = n - 1;
      open_end = left ? brk_tbl[hi] : brk_tbl[lo];
      if (cfg_capture && ((!cfg_border && v == open_end) ||
                          (left ? v > brk_tbl[hi] : v < brk_tbl[lo]))) begin
         // beyond the open end: goes to the end bin
         idx  = left ? hi : lo;
         code = idx + 1;
         hit  = 1'b1;
      end else if (!(v < brk_tbl[lo] || v > brk_tbl[hi] ||
                     (v == open_end && !cfg_border))) begin
         while (hi - lo >= 2) begin
            mid = (hi + lo) / 2;
            if (v > brk_tbl[mid] || (left && v == brk_tbl[mid])) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         code = lo + 1 + int'(shift);
         idx  = lo + int'(shift);
         // a single break with the shift would point past the table in use
         if (idx > n - 1) begin
            idx = n - 1;
         end
         hit = 1'b1;
      end
      if (hit) begin
         ans.result = cfg_codes ? VW'(code) : brk_tbl[idx];
         ans.no_bin = 1'b0;
      end
      return ans;
   endfunction

   // Classify value: mostly on or near the breaks in use
   function automatic logic signed [VW-1:0] pick_value(input int n);
      int     r, k;
      longint lo_v, hi_v, tmp;
      r = $urandom_range(99);
      if (n == 0 || r < 10) begin
         return $urandom;
      end
      if (r < 15) begin
         return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      end
      k = $urandom_range(n - 1);
      if (r < 70) begin
         return VW'(longint'(brk_tbl[k]) + longint'($urandom_range(2)) - 1);
      end
      lo_v = brk_tbl[k];
      hi_v = (k < n - 1) ? longint'(brk_tbl[k + 1]) : lo_v + longint'(ONE_Q16);
      if (hi_v < lo_v) begin
         tmp  = lo_v;
         lo_v = hi_v;
         hi_v = tmp;
      end
      return VW'(lo_v + longint'($urandom) % (hi_v - lo_v + 1));
   endfunction

   // Request side idle with start low and junk on the payload
   task automatic idle_cycle();
      start           <= 1'b0;
      req_kind        <= logic'($urandom_range(1));
      req_entry_index <= INDEX_W'($urandom);
      req_sample      <= $urandom;
      req_is_missing  <= logic'($urandom_range(1));
      @(posedge clock);
   endtask

   // Send one request beat and update the predictor once it is taken.
   // start is left high so back-to-back beats need no second assignment.
   task automatic send_beat(input logic kind, input logic [INDEX_W-1:0] idx,
                            input logic signed [VW-1:0] v, input logic missing);
      while ($urandom_range(99) < sender_idle_pct) begin
         idle_cycle();
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_entry_index <= idx;
      req_sample      <= v;
      req_is_missing  <= missing;
      do @(posedge clock); while (busy);
      if (kind == KIND_LOAD) begin
         brk_tbl[idx] = v;
      end else begin
         pending_bins.push_back(predict_bin(v, missing));
      end
   endtask

   task automatic load_entry(input int idx, input logic signed [VW-1:0] v);
      send_beat(KIND_LOAD, INDEX_W'(idx), v, logic'($urandom_range(1)));
   endtask

   task automatic classify(input logic signed [VW-1:0] v, input logic missing = 1'b0);
      send_beat(KIND_CLASSIFY, INDEX_W'($urandom), v, missing);
   endtask

   // Drain: no beat in flight, loads included
   task automatic settle_pipeline();
      start <= 1'b0;
      while (pending_bins.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // One register write beat
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BREAK_COUNT:    cfg_count   = data;
         CSR_RIGHT_CLOSED:   cfg_right   = data[0];
         CSR_INCLUDE_BORDER: cfg_border  = data[0];
         CSR_CAPTURE_RANGE:  cfg_capture = data[0];
         CSR_RETURN_CODES:   cfg_codes   = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Reset settings: count 2, right-closed, open border, no capture, codes
   task automatic test_default_settings();
      load_entry(0, -2 * ONE_Q16);
      load_entry(1, '0);
      load_entry(2, ONE_Q16 + ONE_Q16 / 2);
      load_entry(3, 3 * ONE_Q16);
      classify(-2 * ONE_Q16);      // open lower border
      classify(-ONE_Q16);
      classify('0);                // closed upper border
      classify(VALUE_MAX);         // above all breaks
      classify('0, 1'b1);          // missing value
   endtask

   // Capture into the end bins, right-closed, with shifted codes
   task automatic test_out_of_range_capture();
      settle_pipeline();
      csr_write(CSR_BREAK_COUNT, 7'd4);
      csr_write(CSR_CAPTURE_RANGE, 7'd1);
      classify(VALUE_MIN);
      classify(-2 * ONE_Q16);      // equal to the open end goes to the end bin
      classify(ONE_Q16);
   endtask

   // Single break with shifted index, then an empty table
   task automatic test_single_and_empty_table();
      settle_pipeline();
      csr_write(CSR_BREAK_COUNT, 7'd1);
      csr_write(CSR_RETURN_CODES, 7'd0);
      classify(-2 * ONE_Q16);
      settle_pipeline();
      csr_write(CSR_INCLUDE_BORDER, 7'd1);
      classify(-2 * ONE_Q16);      // break index clamps to the last break
      settle_pipeline();
      csr_write(CSR_BREAK_COUNT, 7'd0);
      classify(ONE_Q16);
   endtask

   // Left-closed bins, spare register index, extreme load values
   task automatic test_left_closed();
      settle_pipeline();
      csr_write(CSR_BREAK_COUNT, 7'd4);
      csr_write(CSR_RIGHT_CLOSED, 7'd0);
      csr_write(CSR_INCLUDE_BORDER, 7'd0);
      csr_write(CSR_CAPTURE_RANGE, 7'd0);
      csr_write(CSR_RETURN_CODES, 7'd1);
      csr_write(CSR_SPARE_FIRST, 7'h7f);
      classify(3 * ONE_Q16);       // open upper border
      classify(-2 * ONE_Q16);
      classify('0);
      classify(VALUE_MIN);
      load_entry(62, VALUE_MIN);
      load_entry(63, VALUE_MAX);
   endtask

   // Rewrite the whole table in ascending order, wide or clustered
   task automatic load_sorted_table(input bit wide);
      longint acc, step;
      acc = wide ? longint'(VALUE_MIN) + longint'($urandom_range(0, 1 << 25))
                 : longint'(int'($urandom_range(0, 65535)) - 32768) * 256;
      for (int i = 0; i < MAX_BREAKS; i++) begin
         load_entry(i, VW'(acc));
         if (wide) begin
            step = $urandom_range(0, 1 << 26);
         end else begin
            step = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 70000);
         end
         acc = acc + step;
         if (acc > longint'(VALUE_MAX)) begin
            acc = VALUE_MAX;
         end
      end
   endtask

   // One table entry rewrite, mostly keeping the order, sometimes breaking it
   task automatic random_load();
      int     idx;
      longint lo_v, hi_v;
      idx = $urandom_range(MAX_BREAKS - 1);
      lo_v = (idx > 0) ? longint'(brk_tbl[idx - 1]) : longint'(VALUE_MIN);
      hi_v = (idx < MAX_BREAKS - 1) ? longint'(brk_tbl[idx + 1]) : longint'(VALUE_MAX);
      if ($urandom_range(99) < 80 && hi_v >= lo_v) begin
         load_entry(idx, VW'(lo_v + longint'($urandom) % (hi_v - lo_v + 1)));
      end else begin
         load_entry(idx, $urandom);
      end
   endtask

   // Phases of random traffic, each under its own settings and sender idling
   task automatic test_random_traffic();
      logic [COUNT_W-1:0] count;
      logic [2:0]         ph;
      int                 n;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         ph = 3'(phase);
         case (phase)
            0:       count = 7'd64;
            1:       count = 7'd1;
            2:       count = 7'd2;
            3:       count = 7'd127;
            4:       count = 7'd0;
            5:       count = 7'd65;
            default: count = COUNT_W'($urandom_range(3, MAX_BREAKS));
         endcase
         settle_pipeline();
         csr_write(CSR_BREAK_COUNT, count);
         csr_write(CSR_RIGHT_CLOSED, CSR_DATA_W'(ph[0]));
         csr_write(CSR_INCLUDE_BORDER, CSR_DATA_W'(ph[1]));
         csr_write(CSR_CAPTURE_RANGE, CSR_DATA_W'(ph[2]));
         csr_write(CSR_RETURN_CODES, CSR_DATA_W'(ph[0] ^ ph[2]));
         csr_write(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                   CSR_DATA_W'($urandom));
         case (phase % 4)
            0:       sender_idle_pct = 0;
            1:       sender_idle_pct = 57;
            2:       sender_idle_pct = 0;
            default: sender_idle_pct = 10;
         endcase
         load_sorted_table(ph[0]);
         n = (int'(cfg_count) > MAX_BREAKS) ? MAX_BREAKS : int'(cfg_count);
         for (int i = 0; i < RANDOM_BEATS; i++) begin
            if ($urandom_range(99) < 15) begin
               random_load();
            end else begin
               classify(pick_value(n), logic'($urandom_range(19) == 0));
            end
         end
      end
   endtask

   // Response checker: every strobe must match the oldest pending answer
   always @(posedge clock) begin
      bin_answer_type exp_bin;
      if (!reset && rsp_valid) begin
         if (pending_bins.size() == 0) begin
            $error("unexpected response: result %0d no_bin %0b", rsp_result, rsp_no_bin);
            fail_count++;
         end else begin
            exp_bin = pending_bins.pop_front();
            if (rsp_result !== exp_bin.result) begin
               $error("result mismatch: expected %0d, actual %0d",
                      exp_bin.result, rsp_result);
               fail_count++;
            end
            if (rsp_no_bin !== exp_bin.no_bin) begin
               $error("no_bin mismatch: expected %0b, actual %0b",
                      exp_bin.no_bin, rsp_no_bin);
               fail_count++;
            end
         end
      end
   end

   // Run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MAX_BREAKS; i++) begin
         brk_tbl[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_out_of_range_capture();
      test_single_and_empty_table();
      test_left_closed();
      test_random_traffic();
      settle_pipeline();
      if (pending_bins.size() != 0) begin
         $error("%0d responses never arrived", pending_bins.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
